FILE: rtl/prq_pkg.sv
package prq_pkg;

  localparam int NUM_LEVELS = 6;
  localparam int NUM_SLOTS  = 64;

  localparam int SLOT_W    = 6;
  localparam int LEVEL_W   = 3;
  localparam int COUNT_W   = 7;
  localparam int LVL_IW    = $clog2(NUM_LEVELS);
  localparam int LINK_AW   = $clog2(NUM_SLOTS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  slot;
    logic [LEVEL_W-1:0] level;
  } prq_req_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  out_slot;
    logic [LEVEL_W-1:0] out_level;
  } prq_rsp_t;

  typedef struct packed {
    logic accept_enq;
    logic accept_deq;
    logic load_link;
  } prq_cmd_t;

  typedef struct packed {
    logic any_ready;
    logic need_link;
  } prq_sts_t;

  typedef enum logic [0:0] {
    PRQ_IDLE,
    PRQ_LINK
  } prq_state_t;

endpackage

FILE: rtl/prq_ram.sv
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/prq_ctrl.sv
module prq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_mode,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  prq_pkg::prq_sts_t sts,
  output prq_pkg::prq_cmd_t cmd
);
  import prq_pkg::*;

  prq_state_t state;
  prq_state_t state_next;
  logic       rsp_valid_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PRQ_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid;
    cmd            = '0;
    req_stall      = (state != PRQ_IDLE) || (rsp_valid && rsp_stall);
    accept         = req_valid && !req_stall;
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
    if (accept) begin
      rsp_valid_next = 1'b1;
    end
    unique case (state)
      PRQ_IDLE: begin
        cmd.accept_enq = accept && (req_mode == MODE_ENQ);
        cmd.accept_deq = accept && (req_mode == MODE_DEQ);
        if (cmd.accept_deq && sts.any_ready && sts.need_link) begin
          state_next = PRQ_LINK;
        end
      end
      PRQ_LINK: begin
        cmd.load_link = 1'b1;
        state_next    = PRQ_IDLE;
      end
      default: begin
        state_next = PRQ_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_link_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == PRQ_LINK) |-> req_stall)
    else $error("Request taken while the head link is loading.");

  a_link_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == PRQ_LINK) |=> (state == PRQ_IDLE))
    else $error("Link load lasted more than one cycle.");

  a_link_after_deq: assert property (@(posedge clk) disable iff (rst)
    (state == PRQ_IDLE && state_next == PRQ_LINK) |-> cmd.accept_deq)
    else $error("Link load started without a dequeue transaction.");

  a_rsp_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("Accepted transaction produced no response.");
`endif

endmodule

FILE: rtl/prq_dp.sv
module prq_dp (
  input  logic              clk,
  input  logic              rst,
  input  prq_pkg::prq_cmd_t cmd,
  input  prq_pkg::prq_req_t req,
  output prq_pkg::prq_sts_t sts,
  output prq_pkg::prq_rsp_t rsp
);
  import prq_pkg::*;

  logic [SLOT_W-1:0]  head  [NUM_LEVELS];
  logic [SLOT_W-1:0]  tail  [NUM_LEVELS];
  logic [COUNT_W-1:0] count [NUM_LEVELS];
  logic [LVL_IW-1:0]  deq_lvl;

  logic               deq_hit;
  logic [LVL_IW-1:0]  deq_sel;
  logic [LVL_IW-1:0]  enq_idx;
  logic               enq_arg_ok;
  logic [COUNT_W-1:0] enq_cnt;
  logic               enq_ok;

  logic               link_we;
  logic [LINK_AW-1:0] link_waddr;
  logic [LINK_AW-1:0] link_raddr;
  logic [SLOT_W-1:0]  link_rdata;

  always_comb begin
    deq_hit = 1'b0;
    deq_sel = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        deq_hit = 1'b1;
        deq_sel = LVL_IW'(i);
      end
    end
  end

  assign enq_idx    = LVL_IW'(req.level - LEVEL_W'(1));
  assign enq_arg_ok = (req.level != '0) && (32'(req.level) <= NUM_LEVELS)
                      && (32'(req.slot) < NUM_SLOTS);
  assign enq_cnt    = enq_arg_ok ? count[enq_idx] : '0;
  assign enq_ok     = enq_arg_ok && (enq_cnt != COUNT_MAX);

  assign sts.any_ready = deq_hit;
  assign sts.need_link = count[deq_sel] > COUNT_W'(1);

  assign link_we    = cmd.accept_enq && enq_ok && (enq_cnt != '0);
  assign link_waddr = LINK_AW'(tail[enq_idx]);
  assign link_raddr = LINK_AW'(head[deq_sel]);

  prq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (req.slot),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count[i] <= '0;
      end
    end else begin
      if (cmd.accept_enq && enq_ok) begin
        count[enq_idx] <= enq_cnt + COUNT_W'(1);
      end
      if (cmd.accept_deq && deq_hit) begin
        count[deq_sel] <= count[deq_sel] - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_enq) begin
      rsp.found     <= enq_ok;
      rsp.out_slot  <= req.slot;
      rsp.out_level <= req.level;
      if (enq_ok) begin
        if (enq_cnt == '0) begin
          head[enq_idx] <= req.slot;
        end
        tail[enq_idx] <= req.slot;
      end
    end
    if (cmd.accept_deq) begin
      deq_lvl <= deq_sel;
      if (deq_hit) begin
        rsp.found     <= 1'b1;
        rsp.out_slot  <= head[deq_sel];
        rsp.out_level <= LEVEL_W'(deq_sel) + LEVEL_W'(1);
      end else begin
        rsp <= '0;
      end
    end
    if (cmd.load_link) begin
      head[deq_lvl] <= link_rdata;
    end
  end

endmodule

FILE: rtl/priority_ready_queue.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid, req_stall  prq_req_t (mode, slot, level)
// rsp       out        rsp_valid, rsp_stall  prq_rsp_t (found, out_slot, out_level)
//
// A dequeue that leaves its level non-empty also passes through a link-load state,
// because the new head comes from the registered read port of the link memory.
// One response is registered per transaction; a request is taken while no head link
// is loading and the response register is empty or being drained in the same cycle.
// Reset clears the per-level counts and the controller at once; no clearing pass.
// A stalled response holds its value and blocks further requests until it is taken.
module priority_ready_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  prq_pkg::prq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output prq_pkg::prq_rsp_t rsp
);
  import prq_pkg::*;

  prq_cmd_t cmd;
  prq_sts_t sts;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  prq_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

FILE: verif/ready_queue_checker.sv
`timescale 1ns / 1ps

module ready_queue_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  prq_pkg::prq_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  prq_pkg::prq_rsp_t rsp,
  output int                fail_count,
  output int                pending
);
  import prq_pkg::*;

  logic [SLOT_W-1:0]  lvl_head  [NUM_LEVELS];
  logic [SLOT_W-1:0]  lvl_tail  [NUM_LEVELS];
  logic [COUNT_W-1:0] lvl_count [NUM_LEVELS];
  logic [SLOT_W-1:0]  slot_link [NUM_SLOTS];

  prq_rsp_t pending_rsp[$];
  prq_rsp_t oldest_rsp;
  prq_rsp_t predicted_rsp;
  int       errors = 0;

  assign fail_count = errors;

  task automatic next_response(input prq_req_t r, output prq_rsp_t e);
    int idx;
    bit hit;
    e = '0;
    if (r.mode == MODE_ENQ) begin
      e.out_slot  = r.slot;
      e.out_level = r.level;
      if (r.level >= 3'd1 && r.level <= 3'(NUM_LEVELS)) begin
        idx = int'(r.level) - 1;
        if (lvl_count[idx] != COUNT_MAX) begin
          if (lvl_count[idx] == '0) begin
            lvl_head[idx] = r.slot;
          end else begin
            slot_link[lvl_tail[idx]] = r.slot;
          end
          lvl_tail[idx]  = r.slot;
          lvl_count[idx] = lvl_count[idx] + 7'd1;
          e.found        = 1'b1;
        end
      end
    end else begin
      hit = 1'b0;
      for (idx = 0; idx < NUM_LEVELS; idx++) begin
        if (!hit && lvl_count[idx] != '0) begin
          hit         = 1'b1;
          e.found     = 1'b1;
          e.out_slot  = lvl_head[idx];
          e.out_level = 3'(idx + 1);
          if (lvl_count[idx] > 7'd1) begin
            lvl_head[idx] = slot_link[lvl_head[idx]];
          end
          lvl_count[idx] = lvl_count[idx] - 7'd1;
        end
      end
    end
  endtask

  task automatic flag_response(input prq_rsp_t want, input prq_rsp_t got, input bit orphan);
    if (errors < 10) begin
      if (orphan) begin
        $display("%0t: response with none pending: found=%0b slot=%0d level=%0d",
                 $time, got.found, got.out_slot, got.out_level);
      end else begin
        $write("%0t: response mismatch: expected found=%0b slot=%0d level=%0d,",
               $time, want.found, want.out_slot, want.out_level);
        $display(" got found=%0b slot=%0d level=%0d",
                 got.found, got.out_slot, got.out_level);
      end
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lvl_head[i]  = '0;
        lvl_tail[i]  = '0;
        lvl_count[i] = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_link[i] = '0;
      end
      pending_rsp.delete();
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          flag_response('0, rsp, 1'b1);
        end else begin
          oldest_rsp = pending_rsp.pop_front();
          if (rsp.found !== oldest_rsp.found || rsp.out_slot !== oldest_rsp.out_slot ||
              rsp.out_level !== oldest_rsp.out_level) begin
            flag_response(oldest_rsp, rsp, 1'b0);
          end
        end
      end
      if (req_valid && !req_stall) begin
        next_response(req, predicted_rsp);
        pending_rsp.push_back(predicted_rsp);
      end
      pending <= pending_rsp.size();
    end
  end

endmodule

FILE: verif/priority_ready_queue_tb.sv
`timescale 1ns / 1ps

module priority_ready_queue_tb;
  import prq_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1300;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  prq_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  prq_rsp_t rsp;
  int       fail_count;
  int       pending;

  int tx_quiet   = 0;
  int rx_quiet   = 0;
  int items_sent = 0;
  int hold_req   = 0;

  priority_ready_queue uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ready_queue_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  task automatic pick_wait(inout int quiet, output int cycles);
    if (quiet > 0) begin
      quiet--;
      cycles = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      quiet  = $urandom_range(15, 60);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 11);
    end
  endtask

  task automatic offer(input prq_req_t item);
    int gap;
    pick_wait(tx_quiet, gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!(req_valid && !req_stall));
    items_sent++;
  endtask

  task automatic enq(input logic [SLOT_W-1:0] s, input logic [LEVEL_W-1:0] l);
    prq_req_t item;
    item.mode  = MODE_ENQ;
    item.slot  = s;
    item.level = l;
    offer(item);
  endtask

  task automatic deq();
    prq_req_t item;
    item.mode  = MODE_DEQ;
    item.slot  = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    item.level = LEVEL_W'($urandom_range(0, 7));
    offer(item);
  endtask

  task automatic enq_random();
    logic [LEVEL_W-1:0] l;
    if ($urandom_range(0, 15) == 0) begin
      l = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
    end else begin
      l = LEVEL_W'($urandom_range(1, NUM_LEVELS));
    end
    enq(SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), l);
  endtask

  // Pushes the level past its capacity so the last appends are refused.
  task automatic fill_level(input logic [LEVEL_W-1:0] l);
    for (int i = 0; i < 140; i++) begin
      enq(SLOT_W'(i % NUM_SLOTS), l);
    end
  endtask

  initial begin
    int hold_seen;
    int n;
    hold_seen = 0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        n = HOLD_CYCLES;
      end else begin
        pick_wait(rx_quiet, n);
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  initial begin
    int       pick;
    bit       refilled;
    prq_req_t item;
    refilled  = 1'b0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    deq();
    enq(6'd0, 3'd1);
    enq(6'd63, 3'd6);
    enq(6'd5, 3'd3);
    enq(6'd10, 3'd1);
    enq(6'd7, 3'd0);
    enq(6'd42, 3'd7);
    repeat (5) deq();
    enq(6'd33, 3'd2);
    enq(6'd34, 3'd4);
    enq(6'd35, 3'd5);
    enq(6'd36, 3'd2);
    repeat (4) deq();
    item.mode  = MODE_DEQ;
    item.slot  = 6'd63;
    item.level = 3'd7;
    offer(item);

    // Every link entry gets written here, the last as slot 0 recurs.
    hold_req++;
    fill_level(LEVEL_W'($urandom_range(1, NUM_LEVELS)));
    repeat (60) deq();

    while (items_sent < ITEM_TARGET) begin
      if (!refilled && items_sent > 700) begin
        refilled = 1'b1;
        hold_req++;
        fill_level(LEVEL_W'($urandom_range(1, NUM_LEVELS)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 12)) enq_random();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 14)) deq();
      end else if (pick < 95) begin
        item = prq_req_t'(10'($urandom_range(0, 1023)));
        offer(item);
      end else begin
        repeat (20) deq();
      end
    end
    req_valid <= 1'b0;

    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_ctrl.sv
rtl/prq_dp.sv
rtl/priority_ready_queue.sv
verif/ready_queue_checker.sv
verif/priority_ready_queue_tb.sv
